@@ rtl/hps_pkg.sv @@
// Shared constants, types and helper function of the halfcomplex power spectrum block.
`default_nettype none
package hps_pkg;

    localparam int MAX_LENGTH   = 2048;
    localparam int COEF_WIDTH   = 24;

    localparam int CFG_WIDTH    = 12;
    localparam int LEN_WIDTH    = $clog2(MAX_LENGTH + 1);
    localparam int STORE_DEPTH  = MAX_LENGTH / 2 + 1;
    localparam int BIN_WIDTH    = $clog2(STORE_DEPTH);
    localparam int SQ_WIDTH     = 2 * COEF_WIDTH;
    localparam int PW_WIDTH     = SQ_WIDTH + 1;
    localparam int POWER_WIDTH  = 48;
    localparam int SUM_WIDTH    = 57;
    localparam int TOTAL_WIDTH  = 58;

    localparam int PDATA_WIDTH  = 32;
    localparam int PADDR_WIDTH  = 3;
    localparam int REG_IDX_WIDTH = PADDR_WIDTH - 2;
    localparam logic [REG_IDX_WIDTH-1:0] REG_TRANSFORM_LENGTH = REG_IDX_WIDTH'(0);

    localparam int FIFO_DEPTH   = 8;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = FIFO_PTR_W + 2;

    typedef logic [BIN_WIDTH-1:0]   t_bin;
    typedef logic [PW_WIDTH-1:0]    t_pw;

    typedef struct packed {
        t_bin                       bin;
        logic [POWER_WIDTH-1:0]     power;
        logic                       final_item;
        t_bin                       peak;
        t_bin                       trough;
        logic [TOTAL_WIDTH-1:0]     total;
    } t_entry;

    // absolute value of a two's complement coefficient, as unsigned
    function automatic logic [COEF_WIDTH-1:0] coef_mag(input logic [COEF_WIDTH-1:0] v);
        logic [COEF_WIDTH-1:0] neg;
        neg = ~v + 1'b1;
        return v[COEF_WIDTH-1] ? neg : v;
    endfunction

endpackage
`default_nettype wire

@@ rtl/hps_coef_if.sv @@
// Input channel: one halfcomplex coefficient per request.
`default_nettype none
interface hps_coef_if;
    import hps_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [COEF_WIDTH-1:0] coef;

    modport source (output valid, output coef, input ready);
    modport sink   (input valid, input coef, output ready);
endinterface
`default_nettype wire

@@ rtl/hps_result_if.sv @@
// Output channel: one bin power or end-of-frame summary per request.
`default_nettype none
interface hps_result_if;
    import hps_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [BIN_WIDTH-1:0]    bin_index;
    logic [POWER_WIDTH-1:0]  bin_power;
    logic                    is_summary;
    logic [BIN_WIDTH-1:0]    peak_bin;
    logic [BIN_WIDTH-1:0]    trough_bin;
    logic [TOTAL_WIDTH-1:0]  total_power;
    logic                    last;

    modport source (output valid, output bin_index, output bin_power, output is_summary,
                    output peak_bin, output trough_bin, output total_power, output last,
                    input ready);
    modport sink   (input valid, input bin_index, input bin_power, input is_summary,
                    input peak_bin, input trough_bin, input total_power, input last,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/halfcomplex_power_spectrum.sv @@
// A bin result passes stages s1, s2, s3 and the result queue after its coefficient request is accepted.
// One coefficient per cycle while the queue has room; the last item of a frame also yields a
// summary request, absorbed by an 8-entry result queue that sets when input stalls.
// Real parts sit in a 1025 x 24 RAM, written once and read once per frame (no clearing).
// Reset (synchronous): length 2048, frame position 0, statistics and queue cleared.
`default_nettype none
module halfcomplex_power_spectrum (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    hps_coef_if.sink                            i_coef,
    hps_result_if.source                        o_result,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [hps_pkg::PADDR_WIDTH-1:0] paddr,
    input  wire logic [hps_pkg::PDATA_WIDTH-1:0] pwdata,
    output logic      [hps_pkg::PDATA_WIDTH-1:0] prdata,
    output logic                                pready
);
    import hps_pkg::*;

    // configuration
    logic [LEN_WIDTH-1:0]   r_len;
    logic [LEN_WIDTH-1:0]   r_count;
    logic                   cfg_sel;
    logic                   cfg_wr;
    logic [CFG_WIDTH-1:0]   cfg_val;
    logic [LEN_WIDTH-1:0]   cfg_len;

    // front end
    logic                   accept;
    logic [LEN_WIDTH-1:0]   idx;
    logic [LEN_WIDTH:0]     twice;
    logic [LEN_WIDTH-1:0]   diff;
    logic                   is_final;
    logic                   is_dc;
    logic                   is_store;
    logic                   is_nyq;
    logic                   is_pair;
    t_bin                   bin;
    logic [COEF_WIDTH-1:0]  rd_data;

    // pipeline
    logic                   r_s1_valid, r_s1_pair, r_s1_final;
    t_bin                   r_s1_bin;
    logic [COEF_WIDTH-1:0]  r_s1_coef;
    logic                   r_s2_valid, r_s2_final;
    t_bin                   r_s2_bin;
    logic [SQ_WIDTH-1:0]    r_s2_sq_c, r_s2_sq_r;
    logic [COEF_WIDTH-1:0]  mag_c, mag_r;
    logic [SQ_WIDTH-1:0]    sq_c, sq_r;
    logic                   r_s3_valid, r_s3_final;
    t_bin                   r_s3_bin;
    t_pw                    r_s3_pw;

    // statistics
    t_pw                    r_peak_pw, n_peak_pw;
    t_pw                    r_trough_pw, n_trough_pw;
    t_bin                   r_peak_idx, n_peak_idx;
    t_bin                   r_trough_idx, n_trough_idx;
    logic [SUM_WIDTH-1:0]   r_sum, n_sum;

    // result queue
    t_entry                 r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0]  r_fifo_count;
    logic [FIFO_CNT_W-1:0]  pending;
    logic                   r_phase;
    t_entry                 head;
    logic                   push, pop, out_fire;
    t_entry                 push_entry;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[PADDR_WIDTH-1:2] == REG_TRANSFORM_LENGTH);
    assign cfg_wr  = psel && penable && pwrite && cfg_sel;
    assign cfg_val = pwdata[CFG_WIDTH-1:0];
    assign prdata  = cfg_sel ? PDATA_WIDTH'(r_len) : '0;

    always_comb begin
        if (cfg_val == '0) begin
            cfg_len = LEN_WIDTH'(1);
        end else if (32'(cfg_val) > 32'(MAX_LENGTH)) begin
            cfg_len = LEN_WIDTH'(MAX_LENGTH);
        end else begin
            cfg_len = LEN_WIDTH'(cfg_val);
        end
    end

    // ---------------- front end: classify and access the store ----------------
    assign pending = r_fifo_count + FIFO_CNT_W'(r_s1_valid) + FIFO_CNT_W'(r_s2_valid)
                     + FIFO_CNT_W'(r_s3_valid);
    assign i_coef.ready = (pending < FIFO_CNT_W'(FIFO_DEPTH));
    assign accept = i_coef.valid && i_coef.ready;

    always_comb begin
        idx      = (r_count >= r_len) ? '0 : r_count;
        twice    = {idx, 1'b0};
        diff     = r_len - idx;
        is_final = ({1'b0, idx} + 1'b1) >= {1'b0, r_len};
        is_dc    = (idx == '0);
        is_store = !is_dc && (twice < {1'b0, r_len});
        is_nyq   = !is_dc && (twice == {1'b0, r_len});
        is_pair  = !is_dc && (twice > {1'b0, r_len});
        if (is_pair) begin
            bin = diff[BIN_WIDTH-1:0];
        end else if (is_nyq) begin
            bin = idx[BIN_WIDTH-1:0];
        end else begin
            bin = '0;
        end
    end

    hps_ram #(
        .WIDTH (COEF_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_real_store (
        .i_clk     (i_clk),
        .i_wr_en   (accept && is_store),
        .i_wr_addr (idx[BIN_WIDTH-1:0]),
        .i_wr_data (i_coef.coef),
        .i_rd_addr (diff[BIN_WIDTH-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= LEN_WIDTH'(MAX_LENGTH);
            r_count <= '0;
        end else if (cfg_wr) begin
            r_len   <= cfg_len;
            r_count <= '0;
        end else if (accept) begin
            r_count <= is_final ? '0 : idx + 1'b1;
        end
    end

    // ---------------- squares ----------------
    assign mag_c = coef_mag(r_s1_coef);
    assign mag_r = coef_mag(rd_data);
    assign sq_c  = SQ_WIDTH'(mag_c) * SQ_WIDTH'(mag_c);
    assign sq_r  = r_s1_pair ? SQ_WIDTH'(mag_r) * SQ_WIDTH'(mag_r) : '0;

    // store-only items never end a frame, so only bin items travel on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept && !is_store;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_pair  <= is_pair;
        r_s1_final <= is_final;
        r_s1_bin   <= bin;
        r_s1_coef  <= i_coef.coef;
        r_s2_final <= r_s1_final;
        r_s2_bin   <= r_s1_bin;
        r_s2_sq_c  <= sq_c;
        r_s2_sq_r  <= sq_r;
        r_s3_final <= r_s2_final;
        r_s3_bin   <= r_s2_bin;
        r_s3_pw    <= PW_WIDTH'(r_s2_sq_c) + PW_WIDTH'(r_s2_sq_r);
    end

    // ---------------- statistics ----------------
    always_comb begin
        n_peak_pw    = r_peak_pw;
        n_peak_idx   = r_peak_idx;
        n_trough_pw  = r_trough_pw;
        n_trough_idx = r_trough_idx;
        n_sum        = r_sum;
        if (r_s3_bin == '0) begin
            n_peak_pw    = r_s3_pw;
            n_trough_pw  = r_s3_pw;
            n_peak_idx   = '0;
            n_trough_idx = '0;
            n_sum        = '0;
        end else begin
            if (r_s3_pw > r_peak_pw || (r_s3_pw == r_peak_pw && r_s3_bin < r_peak_idx)) begin
                n_peak_pw  = r_s3_pw;
                n_peak_idx = r_s3_bin;
            end
            if (r_s3_pw < r_trough_pw
                || (r_s3_pw == r_trough_pw && r_s3_bin < r_trough_idx)) begin
                n_trough_pw  = r_s3_pw;
                n_trough_idx = r_s3_bin;
            end
            n_sum = r_sum + SUM_WIDTH'(r_s3_pw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_pw    <= '0;
            r_peak_idx   <= '0;
            r_trough_pw  <= '0;
            r_trough_idx <= '0;
            r_sum        <= '0;
        end else if (r_s3_valid) begin
            r_peak_pw    <= n_peak_pw;
            r_peak_idx   <= n_peak_idx;
            r_trough_pw  <= n_trough_pw;
            r_trough_idx <= n_trough_idx;
            r_sum        <= n_sum;
        end
    end

    // ---------------- result queue ----------------
    always_comb begin
        push_entry.bin        = r_s3_bin;
        push_entry.power      = r_s3_pw[POWER_WIDTH-1:0];
        push_entry.final_item = r_s3_final;
        push_entry.peak       = n_peak_idx;
        push_entry.trough     = n_trough_idx;
        push_entry.total      = TOTAL_WIDTH'(n_sum);
    end

    assign head     = r_fifo[r_rd_ptr];
    assign push     = r_s3_valid;
    assign out_fire = o_result.valid && o_result.ready;
    // a frame's last entry goes out twice: bin result, then summary
    assign pop      = out_fire && (r_phase || !head.final_item);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_fifo_count <= '0;
            r_phase      <= 1'b0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_fifo_count <= r_fifo_count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
            if (out_fire) begin
                r_phase <= !pop;
            end
        end
    end

    assign o_result.valid       = (r_fifo_count != '0);
    assign o_result.is_summary  = r_phase;
    assign o_result.bin_index   = r_phase ? '0 : head.bin;
    assign o_result.bin_power   = r_phase ? '0 : head.power;
    assign o_result.peak_bin    = r_phase ? head.peak : '0;
    assign o_result.trough_bin  = r_phase ? head.trough : '0;
    assign o_result.total_power = r_phase ? head.total : '0;
    assign o_result.last        = r_phase || !head.final_item;

endmodule
`default_nettype wire

@@ rtl/hps_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none
module hps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire

@@ rtl/hps_checker.sv @@
// Port-level checks on the result stream, bound to the top level.
`default_nettype none
module hps_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [10:0] i_bin_index,
    input wire logic [47:0] i_bin_power,
    input wire logic        i_is_summary,
    input wire logic [10:0] i_peak_bin,
    input wire logic [10:0] i_trough_bin,
    input wire logic [57:0] i_total_power,
    input wire logic        i_last
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_bin_index)
            && $stable(i_bin_power) && $stable(i_is_summary) && $stable(i_total_power)
            && $stable(i_last))
        else $error("result changed while stalled");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_is_summary |-> i_last && i_bin_index == 11'd0
            && i_bin_power == 48'd0)
        else $error("summary request malformed");

    a_bin_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_is_summary |-> i_peak_bin == 11'd0 && i_trough_bin == 11'd0
            && i_total_power == 58'd0)
        else $error("bin request carries summary fields");

    a_summary_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_is_summary && !i_last
            |=> i_out_valid && i_is_summary)
        else $error("summary missing after final bin");
endmodule

bind halfcomplex_power_spectrum hps_checker u_hps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_bin_index   (o_result.bin_index),
    .i_bin_power   (o_result.bin_power),
    .i_is_summary  (o_result.is_summary),
    .i_peak_bin    (o_result.peak_bin),
    .i_trough_bin  (o_result.trough_bin),
    .i_total_power (o_result.total_power),
    .i_last        (o_result.last)
);
`default_nettype wire

@@ sim/halfcomplex_power_spectrum_checker.sv @@
// Scoreboard for the halfcomplex power spectrum block: predicts bin powers and frame summaries.
module halfcomplex_power_spectrum_checker import hps_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    hps_coef_if                    coef_ch,
    hps_result_if                  result_ch,
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic                   i_pready,
    input  logic [PADDR_WIDTH-1:0] i_paddr,
    input  logic [PDATA_WIDTH-1:0] i_pwdata,
    output int                     o_errors,
    output int                     o_pending,
    output int                     o_checked,
    output int                     o_summaries
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_bin                   bin;
        logic [POWER_WIDTH-1:0] power;
        logic                   summary;
        t_bin                   peak;
        t_bin                   trough;
        logic [TOTAL_WIDTH-1:0] total;
        logic                   last;
    } spectrum_result_t;

    spectrum_result_t expected_powers[$];

    logic signed [COEF_WIDTH-1:0] real_part_mem [STORE_DEPTH];
    int                           frame_len;
    int                           frame_pos;
    logic [POWER_WIDTH-1:0]       loudest_pw;
    int                           loudest_bin;
    logic [POWER_WIDTH-1:0]       quietest_pw;
    int                           quietest_bin;
    logic [SUM_WIDTH-1:0]         nondc_sum;
    int                           mismatch_count = 0;
    int                           checked_count = 0;
    int                           summary_count = 0;

    function automatic logic [POWER_WIDTH-1:0] coef_energy(input logic signed [COEF_WIDTH-1:0] c);
        longint m;
        m = c;
        if (m < 0) begin
            m = -m;
        end
        return POWER_WIDTH'(m * m);
    endfunction

    function automatic void set_length(input logic [PDATA_WIDTH-1:0] value);
        int len;
        len = int'(value[CFG_WIDTH-1:0]);
        if (len == 0) begin
            len = 1;
        end
        if (len > MAX_LENGTH) begin
            len = MAX_LENGTH;
        end
        frame_len = len;
        frame_pos = 0;
    endfunction

    function automatic void predict_bins(input logic signed [COEF_WIDTH-1:0] c);
        int                     pos;
        int                     bin;
        bit                     is_final;
        bit                     has_bin;
        logic [POWER_WIDTH-1:0] pw;
        spectrum_result_t       r;
        pos = frame_pos;
        if (pos >= frame_len) begin
            pos = 0;
        end
        is_final = (pos + 1 >= frame_len);
        has_bin = 1'b1;
        bin = pos;
        pw = coef_energy(c);
        if (pos != 0 && 2 * pos < frame_len) begin
            real_part_mem[pos] = c;
            has_bin = 1'b0;
        end else if (pos != 0 && 2 * pos > frame_len) begin
            bin = frame_len - pos;
            pw = coef_energy(real_part_mem[bin]) + coef_energy(c);
        end
        if (has_bin) begin
            if (bin == 0) begin
                loudest_pw = pw;
                quietest_pw = pw;
                loudest_bin = 0;
                quietest_bin = 0;
                nondc_sum = '0;
            end else begin
                if (pw > loudest_pw || (pw == loudest_pw && bin < loudest_bin)) begin
                    loudest_pw = pw;
                    loudest_bin = bin;
                end
                if (pw < quietest_pw || (pw == quietest_pw && bin < quietest_bin)) begin
                    quietest_pw = pw;
                    quietest_bin = bin;
                end
                nondc_sum = nondc_sum + SUM_WIDTH'(pw);
            end
            r = '{bin: t_bin'(bin), power: pw, summary: 1'b0, peak: '0, trough: '0,
                  total: '0, last: !is_final};
            expected_powers.push_back(r);
        end
        if (is_final) begin
            r = '{bin: '0, power: '0, summary: 1'b1, peak: t_bin'(loudest_bin),
                  trough: t_bin'(quietest_bin), total: TOTAL_WIDTH'(nondc_sum), last: 1'b1};
            expected_powers.push_back(r);
            frame_pos = 0;
        end else begin
            frame_pos = pos + 1;
        end
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void check_result();
        spectrum_result_t want;
        if (expected_powers.size() == 0) begin
            $error("unexpected result request: bin_index %0d is_summary %0d",
                   result_ch.bin_index, result_ch.is_summary);
            mismatch_count++;
        end else begin
            want = expected_powers.pop_front();
            compare_field("bin_index", 64'(want.bin), 64'(result_ch.bin_index));
            compare_field("bin_power", 64'(want.power), 64'(result_ch.bin_power));
            compare_field("is_summary", 64'(want.summary), 64'(result_ch.is_summary));
            compare_field("peak_bin", 64'(want.peak), 64'(result_ch.peak_bin));
            compare_field("trough_bin", 64'(want.trough), 64'(result_ch.trough_bin));
            compare_field("total_power", 64'(want.total), 64'(result_ch.total_power));
            compare_field("last", 64'(want.last), 64'(result_ch.last));
            checked_count++;
            if (want.summary) begin
                summary_count++;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_powers.delete();
            frame_len = MAX_LENGTH;
            frame_pos = 0;
            loudest_pw = '0;
            loudest_bin = 0;
            quietest_pw = '0;
            quietest_bin = 0;
            nondc_sum = '0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                && i_paddr[PADDR_WIDTH-1:2] == REG_TRANSFORM_LENGTH) begin
                set_length(i_pwdata);
            end
            if (coef_ch.valid && coef_ch.ready) begin
                predict_bins(coef_ch.coef);
            end
            if (result_ch.valid && result_ch.ready) begin
                check_result();
            end
        end
        o_errors <= mismatch_count;
        o_pending <= expected_powers.size();
        o_checked <= checked_count;
        o_summaries <= summary_count;
    end

endmodule

@@ sim/halfcomplex_power_spectrum_tb.sv @@
// Top testbench of the halfcomplex power spectrum block: clock, reset, stimulus and verdict.
module halfcomplex_power_spectrum_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hps_pkg::*;

    localparam int RANDOM_ITEMS   = 1150;
    localparam int DRAIN_CYCLES   = 12;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic signed [COEF_WIDTH-1:0] COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
    localparam logic signed [COEF_WIDTH-1:0] COEF_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_WIDTH-1:0] paddr;
    logic [PDATA_WIDTH-1:0] pwdata;
    logic [PDATA_WIDTH-1:0] prdata;
    logic                   pready;

    int errors;
    int pending;
    int checked;
    int summaries;
    int tx_gap_max = 2;
    int rx_gap_max = 2;
    bit rx_hold_request = 1'b0;
    int coefs_sent = 0;
    int lengths_written = 0;
    int idle_cycles = 0;

    hps_coef_if   coef_ch();
    hps_result_if result_ch();

    halfcomplex_power_spectrum dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_coef   (coef_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    halfcomplex_power_spectrum_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .coef_ch     (coef_ch),
        .result_ch   (result_ch),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_summaries (summaries)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic signed [COEF_WIDTH-1:0] pick_coef();
        case ($urandom_range(0, 7))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return COEF_WIDTH'(int'($urandom_range(0, 8)) - 4);
            default: return COEF_WIDTH'($urandom);
        endcase
    endfunction

    function automatic int pick_gap_max();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 3;
            default: return 18;
        endcase
    endfunction

    task automatic send_coef(input logic signed [COEF_WIDTH-1:0] value);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            coef_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        coef_ch.valid <= 1'b1;
        coef_ch.coef <= value;
        do @(posedge i_clk); while (!coef_ch.ready);
        coefs_sent++;
    endtask

    task automatic send_random_coefs(input int count);
        repeat (count) send_coef(pick_coef());
    endtask

    // drop valid, wait out every pending result and the pipeline behind it
    task automatic settle();
        coef_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [PDATA_WIDTH-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_TRANSFORM_LENGTH, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        lengths_written++;
    endtask

    // result sink: random hold-off per request, one long stall on demand
    initial begin
        int gap;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rx_hold_request) begin
                gap = HOLD_CYCLES;
                rx_hold_request = 1'b0;
            end else begin
                gap = $urandom_range(0, rx_gap_max);
            end
            if (gap > 0) begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!result_ch.valid);
        end
    end

    always @(posedge i_clk) begin
        if ((coef_ch.valid && coef_ch.ready) || (result_ch.valid && result_ch.ready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("halfcomplex_power_spectrum test failed");
                $finish;
            end
        end
    end

    initial begin
        int random_start;
        int len;
        int frames;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        coef_ch.valid <= 1'b0;
        coef_ch.coef <= '0;
        result_ch.ready <= 1'b0;
        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset length, left mid-frame by the next write
        send_coef(1);
        send_coef(-1);
        settle();
        // oversized length saturates, again cut short
        write_length(4095);
        send_coef(COEF_MAX);
        send_coef(COEF_MIN);
        settle();
        // zero length behaves as a one-coefficient frame
        write_length(0);
        send_coef(COEF_MAX);
        send_coef(COEF_MIN);
        settle();
        write_length(2);
        send_coef(COEF_MIN);
        send_coef(COEF_MAX);
        settle();
        write_length(3);
        send_coef(1);
        send_coef(-1);
        send_coef(0);
        settle();
        write_length(5);
        send_coef(0);
        send_coef(-1);
        send_coef(1);
        send_coef(COEF_MAX);
        send_coef(COEF_MIN);
        settle();
        // equal powers: peak and trough ties resolve to the lower bin
        write_length(6);
        send_coef(5);
        send_coef(-5);
        send_coef(5);
        send_coef(-5);
        send_coef(5);
        send_coef(-5);
        settle();

        random_start = coefs_sent;
        // back-pressure: sink stalls while the source streams full frames
        tx_gap_max = 0;
        rx_gap_max = 0;
        rx_hold_request = 1'b1;
        write_length(40);
        send_random_coefs(160);
        settle();

        while (coefs_sent - random_start < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: len = $urandom_range(65, 300);
                1: len = $urandom_range(1, 4);
                default: len = $urandom_range(5, 64);
            endcase
            write_length(len);
            tx_gap_max = pick_gap_max();
            rx_gap_max = pick_gap_max();
            frames = (len > 64) ? 1 : $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                if (len > 1 && $urandom_range(0, 7) == 0) begin
                    // truncated frame, restarted by the next length write
                    send_random_coefs($urandom_range(1, len - 1));
                    break;
                end
                send_random_coefs(len);
            end
            settle();
        end

        $display("Sent %0d coefficient requests under %0d length writes, frames of 1 to 300 points.",
                 coefs_sent, lengths_written);
        $display("Checked %0d results, %0d of them frame summaries.", checked, summaries);
        if (errors == 0 && pending == 0) begin
            $display("halfcomplex_power_spectrum test passed");
        end else begin
            $display("halfcomplex_power_spectrum test failed");
        end
        $finish;
    end

endmodule

@@ halfcomplex_power_spectrum.f @@
rtl/hps_pkg.sv
rtl/hps_coef_if.sv
rtl/hps_result_if.sv
rtl/hps_ram.sv
rtl/halfcomplex_power_spectrum.sv
rtl/hps_checker.sv
sim/halfcomplex_power_spectrum_checker.sv
sim/halfcomplex_power_spectrum_tb.sv
